// ===== sv/gtg_pkg.sv =====
package gtg_pkg;

  // Root bits of the distance; the squared distance is at most 34 bits.
  localparam int SQ_STEPS = 17;

  // Internal widths
  localparam int CX_W = 36;   // CORDIC x/y: 17-bit delta scaled by 2^16, plus gain growth
  localparam int CZ_W = 24;   // CORDIC angle, Q.20 radians

  localparam logic signed [CZ_W-1:0] HALF_PI_Q20 = 24'sd1647099;
  localparam logic [16:0]            ARRIVE_Q12  = 17'd614;
  localparam logic signed [16:0]     MIN_ANG_Q12 = 17'sd4;
  localparam logic signed [16:0]     PI_Q12      = 17'sd12868;
  localparam logic signed [16:0]     TWO_PI_Q12  = 17'sd25736;

  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_X   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_Y   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIN_GAIN = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ANG_GAIN = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_XL  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_XH  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_YL  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_YH  = 4'd7;

  typedef enum logic [1:0] {
    MODE_ARRIVED = 2'd0,
    MODE_TURN    = 2'd1,
    MODE_DRIVE   = 2'd2
  } drive_mode_t;

  // atan(2^-i) in Q.20 radians
  function automatic logic signed [CZ_W-1:0] gtg_atan(input int i);
    logic signed [CZ_W-1:0] r;
    case (i)
      0:  r = 24'sd823550;
      1:  r = 24'sd486170;
      2:  r = 24'sd256879;
      3:  r = 24'sd130396;
      4:  r = 24'sd65451;
      5:  r = 24'sd32757;
      6:  r = 24'sd16383;
      7:  r = 24'sd8192;
      8:  r = 24'sd4096;
      9:  r = 24'sd2048;
      10: r = 24'sd1024;
      11: r = 24'sd512;
      12: r = 24'sd256;
      13: r = 24'sd128;
      14: r = 24'sd64;
      15: r = 24'sd32;
      16: r = 24'sd16;
      17: r = 24'sd8;
      18: r = 24'sd4;
      19: r = 24'sd2;
      20: r = 24'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/gtg_sqrt.sv =====
module gtg_sqrt #(
  parameter int LAT = 17
) (
  input  logic        clk,
  input  logic        en,
  input  logic [33:0] rad,
  output logic [16:0] root
);
  import gtg_pkg::*;

  logic [34:0] rem   [LAT];
  logic [16:0] q     [LAT];
  logic [34:0] rem_in[LAT];
  logic [16:0] q_in  [LAT];

  genvar j;
  for (j = 0; j < LAT; j++) begin : g_stg
    if (j == 0) begin : g_first
      assign rem_in[j] = {1'b0, rad};
      assign q_in[j]   = '0;
    end else begin : g_next
      assign rem_in[j] = rem[j-1];
      assign q_in[j]   = q[j-1];
    end

    if (j < SQ_STEPS) begin : g_step
      localparam int I = SQ_STEPS - 1 - j;
      logic [34:0] test;
      // (2q + 1) * 4^I with q holding the root bits above bit I
      assign test = ({18'b0, q_in[j]} << (I + 1)) + (35'd1 << (2 * I));
      always_ff @(posedge clk) begin
        if (en) begin
          if (rem_in[j] >= test) begin
            rem[j] <= rem_in[j] - test;
            q[j]   <= q_in[j] | (17'd1 << I);
          end else begin
            rem[j] <= rem_in[j];
            q[j]   <= q_in[j];
          end
        end
      end
    end else begin : g_pass
      always_ff @(posedge clk) begin
        if (en) begin
          rem[j] <= rem_in[j];
          q[j]   <= q_in[j];
        end
      end
    end
  end

  assign root = q[LAT-1];

endmodule

// ===== sv/gtg_cordic.sv =====
module gtg_cordic #(
  parameter int STEPS = 16,
  parameter int LAT   = 17
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [gtg_pkg::CX_W-1:0] x,
  input  logic signed [gtg_pkg::CX_W-1:0] y,
  input  logic signed [gtg_pkg::CZ_W-1:0] z,
  output logic signed [gtg_pkg::CZ_W-1:0] angle
);
  import gtg_pkg::*;

  logic signed [CX_W-1:0] xr  [LAT];
  logic signed [CX_W-1:0] yr  [LAT];
  logic signed [CZ_W-1:0] zr  [LAT];
  logic signed [CX_W-1:0] x_in[LAT];
  logic signed [CX_W-1:0] y_in[LAT];
  logic signed [CZ_W-1:0] z_in[LAT];

  genvar j;
  for (j = 0; j < LAT; j++) begin : g_stg
    if (j == 0) begin : g_first
      assign x_in[j] = x;
      assign y_in[j] = y;
      assign z_in[j] = z;
    end else begin : g_next
      assign x_in[j] = xr[j-1];
      assign y_in[j] = yr[j-1];
      assign z_in[j] = zr[j-1];
    end

    if (j < STEPS) begin : g_step
      logic signed [CX_W-1:0] xs, ys;
      assign xs = x_in[j] >>> j;
      assign ys = y_in[j] >>> j;
      // rotate toward the x axis; y >= 0 turns clockwise
      always_ff @(posedge clk) begin
        if (en) begin
          if (!y_in[j][CX_W-1]) begin
            xr[j] <= x_in[j] + ys;
            yr[j] <= y_in[j] - xs;
            zr[j] <= z_in[j] + gtg_atan(j);
          end else begin
            xr[j] <= x_in[j] - ys;
            yr[j] <= y_in[j] + xs;
            zr[j] <= z_in[j] - gtg_atan(j);
          end
        end
      end
    end else begin : g_pass
      always_ff @(posedge clk) begin
        if (en) begin
          xr[j] <= x_in[j];
          yr[j] <= y_in[j];
          zr[j] <= z_in[j];
        end
      end
    end
  end

  assign angle = zr[LAT-1];

endmodule

// ===== sv/go_to_goal_steering_unit.sv =====
// Go-to-goal steering. Each item is a pose (x, y in Q4.12 m, heading in Q3.12 rad);
// each result is a speed command toward the configured goal: linear speed is
// floor(distance * linear_gain / 256), angular speed floor(-error * angular_gain / 256),
// both saturated to Q4.12. The error is the CORDIC bearing to the goal minus the
// heading, wrapped once into plus or minus pi. Within 0.15 m the block reports
// arrival with zero speeds; near an edge with error above 0.001 rad it turns only.
// One item enters per clock while the output is not stalled; the bit-per-stage square
// root and the stage-per-step CORDIC run side by side. A stall on the output freezes
// the whole pipeline, so nothing is lost or repeated. Registers are written through
// the cfg port (always ready); the user must write them only while idle (not enforced).
module go_to_goal_steering_unit #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // pos_x[15:0], pos_y[31:16], heading[46:32], zero fill
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // linear_velocity[15:0], angular_velocity[31:16]
  output logic [1:0]  m_tuser,   // drive_mode[1:0]
  // register writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [gtg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [15:0]                      cfg_data
);
  import gtg_pkg::*;

  localparam int NSTG = (CORDIC_STEPS > SQ_STEPS) ? CORDIC_STEPS : SQ_STEPS;

  typedef struct packed {
    logic signed [14:0] hd;
    logic               edge_near;
  } side_t;

  // configuration
  logic signed [15:0] goal_x, goal_y, edge_xl, edge_xh, edge_yl, edge_yh;
  logic [7:0]         lin_gain, ang_gain;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      goal_x   <= 16'sd6861;
      goal_y   <= 16'sd4997;
      lin_gain <= 8'd77;
      ang_gain <= 8'd77;
      edge_xl  <= 16'sd410;
      edge_xh  <= 16'sd410;
      edge_yl  <= 16'sd410;
      edge_yh  <= 16'sd410;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GOAL_X:   goal_x   <= cfg_data;
        REG_GOAL_Y:   goal_y   <= cfg_data;
        REG_LIN_GAIN: lin_gain <= cfg_data[7:0];
        REG_ANG_GAIN: ang_gain <= cfg_data[7:0];
        REG_EDGE_XL:  edge_xl  <= cfg_data;
        REG_EDGE_XH:  edge_xh  <= cfg_data;
        REG_EDGE_YL:  edge_yl  <= cfg_data;
        REG_EDGE_YH:  edge_yh  <= cfg_data;
        default: ;
      endcase
    end
  end

  // whole pipeline advances together; the output register is the last stage
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  logic signed [15:0] px, py;
  logic signed [14:0] hd_in;
  assign px    = s_tdata[15:0];
  assign py    = s_tdata[31:16];
  assign hd_in = s_tdata[46:32];

  // stage 1: deltas and edge test
  logic               v1;
  logic signed [16:0] dx1, dy1;
  side_t              sd1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= s_tvalid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx1 <= {goal_x[15], goal_x} - {px[15], px};
      dy1 <= {goal_y[15], goal_y} - {py[15], py};
      sd1.hd        <= hd_in;
      sd1.edge_near <= (px < edge_xl) || (px > edge_xh) || (py < edge_yl) || (py > edge_yh);
    end
  end

  // stage 2: squares, and quadrant fold for the CORDIC
  logic                   v2;
  logic signed [33:0]     sqx2, sqy2, sqx_c, sqy_c;
  logic signed [CX_W-1:0] cx_c, cy_c, cx2, cy2;
  logic signed [CZ_W-1:0] cz2;
  side_t                  sd2;

  assign sqx_c = dx1 * dx1;
  assign sqy_c = dy1 * dy1;
  assign cx_c  = CX_W'(dx1) <<< 16;
  assign cy_c  = CX_W'(dy1) <<< 16;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx2 <= sqx_c;
      sqy2 <= sqy_c;
      sd2  <= sd1;
      if (dx1[16]) begin
        if (!dy1[16]) begin
          cx2 <= cy_c;
          cy2 <= -cx_c;
          cz2 <= HALF_PI_Q20;
        end else begin
          cx2 <= -cy_c;
          cy2 <= cx_c;
          cz2 <= -HALF_PI_Q20;
        end
      end else begin
        cx2 <= cx_c;
        cy2 <= cy_c;
        cz2 <= '0;
      end
    end
  end

  // stage 3: squared distance
  logic                   v3;
  logic [33:0]            rad3;
  logic signed [CX_W-1:0] cx3, cy3;
  logic signed [CZ_W-1:0] cz3;
  side_t                  sd3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad3 <= $unsigned(sqx2) + $unsigned(sqy2);
      cx3  <= cx2;
      cy3  <= cy2;
      cz3  <= cz2;
      sd3  <= sd2;
    end
  end

  // square root and CORDIC side by side, NSTG stages each
  logic [16:0]            dist_p;
  logic signed [CZ_W-1:0] ang_p;
  logic [NSTG-1:0]        vch;
  side_t                  sdch[NSTG];

  gtg_sqrt #(.LAT(NSTG)) u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (rad3),
    .root (dist_p)
  );

  gtg_cordic #(.STEPS(CORDIC_STEPS), .LAT(NSTG)) u_cordic (
    .clk   (clk),
    .en    (en),
    .x     (cx3),
    .y     (cy3),
    .z     (cz3),
    .angle (ang_p)
  );

  always_ff @(posedge clk) begin
    if (rst) vch <= '0;
    else if (en) vch <= {vch[NSTG-2:0], v3};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sdch[0] <= sd3;
      for (int k = 1; k < NSTG; k++) sdch[k] <= sdch[k-1];
    end
  end

  // stage t1: round bearing, subtract heading, wrap once
  logic                   vt1;
  logic signed [CZ_W-1:0] zrnd;
  logic signed [16:0]     brg, a0, aw;
  logic signed [16:0]     at1;
  logic [16:0]            dist_t1;
  logic                   edge_t1;

  assign zrnd = ang_p + 24'sd128;
  assign brg  = 17'(zrnd >>> 8);
  assign a0   = brg - {{2{sdch[NSTG-1].hd[14]}}, sdch[NSTG-1].hd};

  always_comb begin
    if (a0 > PI_Q12)       aw = a0 - TWO_PI_Q12;
    else if (a0 < -PI_Q12) aw = a0 + TWO_PI_Q12;
    else                   aw = a0;
  end

  always_ff @(posedge clk) begin
    if (rst) vt1 <= 1'b0;
    else if (en) vt1 <= vch[NSTG-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      at1     <= aw;
      dist_t1 <= dist_p;
      edge_t1 <= sdch[NSTG-1].edge_near;
    end
  end

  // stage t2: gain products and mode decision
  logic               vt2;
  logic signed [17:0] neg_a;
  logic signed [26:0] angm_t2;
  logic [24:0]        linm_t2;
  logic               far_t2, turn_t2;

  assign neg_a = -(18'(at1));

  always_ff @(posedge clk) begin
    if (rst) vt2 <= 1'b0;
    else if (en) vt2 <= vt1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angm_t2 <= neg_a * $signed({1'b0, ang_gain});
      linm_t2 <= dist_t1 * lin_gain;
      far_t2  <= dist_t1 > ARRIVE_Q12;
      turn_t2 <= edge_t1 && (at1 > MIN_ANG_Q12);
    end
  end

  // stage t3: scale, saturate, select -> output register
  logic signed [18:0] ang_sh;
  logic [16:0]        lin_sh;
  logic signed [15:0] ang_sat, lin_sat;
  logic signed [15:0] lin_out, ang_out;
  drive_mode_t        mode_out;

  assign ang_sh = 19'(angm_t2 >>> 8);
  assign lin_sh = linm_t2[24:8];

  always_comb begin
    if (ang_sh > 19'sd32767)       ang_sat = 16'sh7fff;
    else if (ang_sh < -19'sd32768) ang_sat = 16'sh8000;
    else                           ang_sat = ang_sh[15:0];
    lin_sat = (lin_sh > 17'd32767) ? 16'sh7fff : lin_sh[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (en) m_tvalid <= vt2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!far_t2) begin
        mode_out <= MODE_ARRIVED;
        lin_out  <= '0;
        ang_out  <= '0;
      end else if (turn_t2) begin
        mode_out <= MODE_TURN;
        lin_out  <= '0;
        ang_out  <= ang_sat;
      end else begin
        mode_out <= MODE_DRIVE;
        lin_out  <= lin_sat;
        ang_out  <= ang_sat;
      end
    end
  end

  assign m_tdata = {ang_out, lin_out};
  assign m_tuser = mode_out;

endmodule
